>>> rtl/b64_pkg.sv
// ----------------------------------------------------------------------------
// b64_pkg: shared types and helpers of the base64 stream encoder
// Holds the group record that the front passes to the back, the padding
// character and the sextet to alphabet mapping.
// ----------------------------------------------------------------------------
package b64_pkg;

	// default depth of the group queue between front and back
	localparam int B64_QUEUE_DEPTH = 2;

	// padding character '='
	localparam logic [6:0] PAD_CHAR = 7'h3D;

	// one group ready for output: three bytes, first byte in the top bits
	typedef struct packed {
		logic [23:0] bits;
		logic [1:0]  npad;     // number of trailing '=' characters (0..2)
		logic        fin;      // group closes the message
	} group_t;

	// standard alphabet: A-Z, a-z, 0-9, '+', '/'
	function automatic logic [6:0] sextet_char(input logic [5:0] v);
		logic [6:0] w;
		logic [6:0] c;
		begin
			w = {1'b0, v};
			if (w < 7'd26) begin
				c = 7'h41 + w;
			end else if (w < 7'd52) begin
				c = 7'h61 + (w - 7'd26);
			end else if (w < 7'd62) begin
				c = 7'h30 + (w - 7'd52);
			end else if (w == 7'd62) begin
				c = 7'h2B;
			end else begin
				c = 7'h2F;
			end
			return c;
		end
	endfunction

endpackage

>>> rtl/b64_front.sv
// ----------------------------------------------------------------------------
// b64_front: byte gathering front end
// Collects raw bytes into groups of three and hands a completed or final
// partial group to the queue, together with its padding count.
// ----------------------------------------------------------------------------
module b64_front
	import b64_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_final,
	output logic       push,
	output group_t     push_group,
	input  logic       queue_full
);

	logic [1:0] pos_q;
	logic [7:0] held0_q;
	logic [7:0] held1_q;
	logic       accept;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;

	// classify the byte by its place in the open group
	always_comb begin
		push            = 1'b0;
		push_group.bits = {held0_q, held1_q, in_byte};
		push_group.npad = 2'd0;
		push_group.fin  = in_final;
		case (pos_q)
			2'd1: begin
				push_group.bits = {held0_q, in_byte, 8'h00};
				push_group.npad = 2'd1;
				push            = accept && in_final;
			end
			2'd2: begin
				push = accept;
			end
			default: begin
				push_group.bits = {in_byte, 16'h0000};
				push_group.npad = 2'd2;
				push            = accept && in_final;
			end
		endcase
	end

	// group position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 2'd0;
		end else if (accept) begin
			if (in_final || pos_q == 2'd2) begin
				pos_q <= 2'd0;
			end else if (pos_q == 2'd1) begin
				pos_q <= 2'd2;
			end else begin
				pos_q <= 2'd1;
			end
		end
	end

	// held bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held0_q <= 8'h00;
			held1_q <= 8'h00;
		end else if (accept && !in_final) begin
			if (pos_q == 2'd1) begin
				held1_q <= in_byte;
			end else if (pos_q != 2'd2) begin
				held0_q <= in_byte;
			end
		end
	end

endmodule

>>> rtl/b64_queue.sv
// ----------------------------------------------------------------------------
// b64_queue: group queue
// Small first-in first-out store of group records between front and back.
// ----------------------------------------------------------------------------
module b64_queue
	import b64_pkg::*;
#(
	parameter int DEPTH = B64_QUEUE_DEPTH
)
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  group_t push_group,
	output logic   full,
	input  logic   pop,
	output logic   not_empty,
	output group_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	group_t          store_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head      = store_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= push_group;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/b64_back.sv
// ----------------------------------------------------------------------------
// b64_back: character emitter
// Walks the head group one sextet a cycle unless the output stalls, maps it to the
// alphabet or to padding, and holds each character in the output register.
// ----------------------------------------------------------------------------
module b64_back
	import b64_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       grp_valid,
	input  group_t     grp,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [6:0] out_char,
	output logic       out_group_end,
	output logic       out_msg_end
);

	logic [1:0] idx_q;
	logic       valid_q;
	logic [6:0] char_q;
	logic       gend_q;
	logic       mend_q;
	logic       load;
	logic       take;
	logic [5:0] sextet;
	logic       is_pad;
	logic [6:0] next_char;
	logic       last_char;

	assign load = !valid_q || out_ready;
	assign take = load && grp_valid;
	assign last_char = (idx_q == 2'd3);
	assign pop = take && last_char;

	// select the sextet and decide on padding
	always_comb begin
		case (idx_q)
			2'd0:    sextet = grp.bits[23:18];
			2'd1:    sextet = grp.bits[17:12];
			2'd2:    sextet = grp.bits[11:6];
			default: sextet = grp.bits[5:0];
		endcase
		is_pad    = ({1'b0, idx_q} >= (3'd4 - {1'b0, grp.npad}));
		next_char = is_pad ? PAD_CHAR : sextet_char(sextet);
	end

	// character index within the group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 2'd0;
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= grp_valid;
			if (grp_valid) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (take) begin
			char_q <= next_char;
			gend_q <= last_char;
			mend_q <= last_char && grp.fin;
		end
	end

	assign out_valid     = valid_q;
	assign out_char      = char_q;
	assign out_group_end = gend_q;
	assign out_msg_end   = mend_q;

endmodule

>>> rtl/base64_stream_encoder.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder: byte stream to base64 characters
// Standard alphabet with '=' padding, one byte in and one character out per
// beat, four characters for every group of three bytes or final partial group.
// ----------------------------------------------------------------------------
// A byte is taken in every cycle while the group queue has room; a group
// leaves as four characters, one a cycle from the output register while the
// sink is ready, so the single-character output stage sets the sustained
// rate. The first character of a group passes through the queue and then
// the output register before it is offered on m_tvalid. m_tlast marks the
// fourth character of every group and m_tuser the last character of a
// message.
module base64_stream_encoder
	import b64_pkg::*;
#(
	parameter int QUEUE_DEPTH = B64_QUEUE_DEPTH
)
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,    // [7:0] data_byte
	input  logic       s_tlast,    // final_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,    // [6:0] out_char, [7] zero
	output logic       m_tlast,    // group_end
	output logic       m_tuser     // [0] message_end
);

	logic       push;
	group_t     push_group;
	logic       queue_full;
	logic       pop;
	logic       grp_valid;
	group_t     head;
	logic [6:0] out_char;

	// front: gather bytes into groups
	b64_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_byte    (s_tdata),
		.in_final   (s_tlast),
		.push       (push),
		.push_group (push_group),
		.queue_full (queue_full)
	);

	// queue of pending groups
	b64_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_group (push_group),
		.full       (queue_full),
		.pop        (pop),
		.not_empty  (grp_valid),
		.head       (head)
	);

	// back: emit characters
	b64_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.grp_valid     (grp_valid),
		.grp           (head),
		.pop           (pop),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_char      (out_char),
		.out_group_end (m_tlast),
		.out_msg_end   (m_tuser)
	);

	assign m_tdata = {1'b0, out_char};

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for base64_stream_encoder
// Feeds raw bytes as directed and random-length messages, checks every output
// character, group end and message end against an encoder model kept in the
// bench, under several patterns of source idling and sink backpressure.
// ----------------------------------------------------------------------------
module tb;
	import b64_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 16;

	// standard alphabet, first character in the top byte
	localparam logic [511:0] B64_ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	typedef struct packed {
		logic [6:0] ch;
		logic       grp_end;
		logic       msg_end;
	} b64_char_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;    // [7:0] data_byte
	logic       s_tlast = 1'b0;     // final_byte
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;            // [6:0] out_char, [7] zero
	logic       m_tlast;            // group_end
	logic       m_tuser;            // [0] message_end

	// encoder model state
	logic [7:0] enc_held0 = 8'h00;
	logic [7:0] enc_held1 = 8'h00;
	logic [1:0] enc_pos = 2'd0;
	b64_char_t  expected_chars[$];

	int err_count = 0;
	int src_idle_pct = 0;
	int snk_stall_pct = 0;
	int hold_request = 0;
	int hold_left = 0;
	int idle_cycles = 0;

	base64_stream_encoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always #2 clk = ~clk;

	function automatic logic [6:0] sextet_to_ascii(input logic [5:0] v);
		logic [7:0] c;
		c = B64_ALPHABET[8 * (63 - int'(v)) +: 8];
		return c[6:0];
	endfunction

	task automatic push_char(input logic [6:0] ch, input logic ge, input logic me);
		b64_char_t e;
		e.ch = ch;
		e.grp_end = ge;
		e.msg_end = me;
		expected_chars.push_back(e);
	endtask

	// model of the encoder: one accepted byte in, zero or four characters out
	task automatic encode_byte(input logic [7:0] b, input logic fin);
		logic [1:0] pos;
		pos = (enc_pos == 2'd3) ? 2'd0 : enc_pos;
		case (pos)
			2'd0: begin
				if (!fin) begin
					enc_held0 = b;
					enc_pos = 2'd1;
				end else begin
					push_char(sextet_to_ascii(b[7:2]), 1'b0, 1'b0);
					push_char(sextet_to_ascii({b[1:0], 4'b0000}), 1'b0, 1'b0);
					push_char(PAD_CHAR, 1'b0, 1'b0);
					push_char(PAD_CHAR, 1'b1, 1'b1);
					enc_pos = 2'd0;
				end
			end
			2'd1: begin
				if (!fin) begin
					enc_held1 = b;
					enc_pos = 2'd2;
				end else begin
					push_char(sextet_to_ascii(enc_held0[7:2]), 1'b0, 1'b0);
					push_char(sextet_to_ascii({enc_held0[1:0], b[7:4]}), 1'b0, 1'b0);
					push_char(sextet_to_ascii({b[3:0], 2'b00}), 1'b0, 1'b0);
					push_char(PAD_CHAR, 1'b1, 1'b1);
					enc_pos = 2'd0;
				end
			end
			default: begin
				push_char(sextet_to_ascii(enc_held0[7:2]), 1'b0, 1'b0);
				push_char(sextet_to_ascii({enc_held0[1:0], enc_held1[7:4]}), 1'b0, 1'b0);
				push_char(sextet_to_ascii({enc_held1[3:0], b[7:6]}), 1'b0, 1'b0);
				push_char(sextet_to_ascii(b[5:0]), 1'b1, fin);
				enc_pos = 2'd0;
			end
		endcase
	endtask

	// sink: random stalls, long hold-offs on request, check each character beat
	always @(posedge clk) begin
		b64_char_t e;
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (m_tvalid && m_tready) begin
			if (expected_chars.size() == 0) begin
				$error("unexpected character beat: tdata %h", m_tdata);
				err_count++;
			end else begin
				e = expected_chars.pop_front();
				if (m_tdata !== {1'b0, e.ch}) begin
					$error("out_char: expected %h, actual %h", {1'b0, e.ch}, m_tdata);
					err_count++;
				end
				if (m_tlast !== e.grp_end) begin
					$error("group_end: expected %b, actual %b", e.grp_end, m_tlast);
					err_count++;
				end
				if (m_tuser !== e.msg_end) begin
					$error("message_end: expected %b, actual %b", e.msg_end, m_tuser);
					err_count++;
				end
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// one byte beat, with random source idling ahead of it
	task automatic send_byte(input logic [7:0] b, input logic fin);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= fin;
		do @(posedge clk); while (!s_tready);
		encode_byte(b, fin);
	endtask

	// stop offering bytes and wait for every pending character
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_chars.size() != 0) @(posedge clk);
	endtask

	// random messages, mostly short, with an occasional stray final flag
	task automatic send_messages(input int count);
		int sent;
		int len;
		logic fin;
		sent = 0;
		while (sent < count) begin
			len = ($urandom_range(99) < 75) ? $urandom_range(1, 9) : $urandom_range(10, 30);
			for (int i = 0; i < len && sent < count; i++) begin
				fin = (i == len - 1) || (sent == count - 1) || ($urandom_range(19) == 0);
				send_byte(8'($urandom_range(255)), fin);
				sent++;
			end
		end
	endtask

	// extremes of the byte, each final position, '+' and '/' characters
	task automatic test_directed();
		src_idle_pct = 0;
		snk_stall_pct = 0;
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'hFB, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'h4D, 1'b0);
		send_byte(8'h61, 1'b0);
		send_byte(8'h6E, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b1);
	endtask

	task automatic test_idle_phases();
		src_idle_pct = 0;
		snk_stall_pct = 0;
		send_messages(85);
		src_idle_pct = 76;
		snk_stall_pct = 0;
		send_messages(85);
		src_idle_pct = 0;
		snk_stall_pct = 76;
		send_messages(85);
		src_idle_pct = 30;
		snk_stall_pct = 30;
		send_messages(85);
	endtask

	// sink holds off long enough for the encoder to fill and stall its input
	task automatic test_backpressure();
		src_idle_pct = 0;
		snk_stall_pct = 0;
		hold_request = 300;
		send_messages(40);
	endtask

	// source pauses with two bytes held until all pending characters are out
	task automatic test_source_pause();
		src_idle_pct = 0;
		snk_stall_pct = 30;
		send_byte(8'($urandom_range(255)), 1'b0);
		send_byte(8'($urandom_range(255)), 1'b0);
		send_byte(8'($urandom_range(255)), 1'b0);
		send_byte(8'($urandom_range(255)), 1'b0);
		send_byte(8'($urandom_range(255)), 1'b0);
		wait_drained();
		send_byte(8'($urandom_range(255)), 1'b1);
		send_messages(4);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_idle_phases();
		test_backpressure();
		test_source_pause();
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/b64_pkg.sv
rtl/b64_front.sv
rtl/b64_queue.sv
rtl/b64_back.sv
rtl/base64_stream_encoder.sv
verif/tb.sv
